@@ hdl/jss_pkg.sv @@
// ----------------------------------------------------------------------------
// jss_pkg
// Shared widths and reset values for the Jacobi five-point stencil sweep.
// ----------------------------------------------------------------------------
package jss_pkg;

	localparam int VAL_W        = 24;
	localparam int IDX_W        = 10;
	localparam int GRID_W       = 11;
	localparam int MAX_SIZE_DEF = 1024;
	localparam int OUT_DATA_W   = 72;

	localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(1024);
	localparam logic [GRID_W-1:0] GRID_MIN   = GRID_W'(3);

endpackage

@@ hdl/jacobi_stencil_sweep.sv @@
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep
// One Jacobi sweep of a square grid streamed in raster order, two line stores.
// ----------------------------------------------------------------------------
//  channel   | direction | content
//  s_*       | in        | tdata[23:0] cell_value
//  m_*       | out       | tdata next_value, row_index, col_index, max_delta; tlast
//  cfg_*     | in        | cfg_data grid_size
//
//  One item per cycle sustained. An accepted cell reads both line stores in the
//  accept cycle, the middle store at its own and the next column; the read stage
//  writes them back on advance and, if a result is due, fills the output register.
//  An interior cell's result is computed in the read stage from the accepted cell
//  below it and offered from the output register. arst_n clears counters, running
//  maximum and valid flags; the line stores hold no reset. A full output register
//  with m_tready low holds the read stage and with it s_tready.
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep #(
	parameter int MAX_SIZE = jss_pkg::MAX_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [jss_pkg::VAL_W-1:0]        s_tdata,   // [23:0] cell_value
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [jss_pkg::OUT_DATA_W-1:0]   m_tdata,   // [23:0] next_value,
	                                                    // [33:24] row_index,
	                                                    // [43:34] col_index,
	                                                    // [67:44] max_delta
	output logic                             m_tlast,   // last_of_sweep
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [jss_pkg::GRID_W-1:0]       cfg_data   // grid_size
);
	import jss_pkg::*;

	localparam int CW     = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
	localparam int NW_RAW = $clog2(MAX_SIZE + 1);
	localparam int NW     = (NW_RAW > GRID_W) ? NW_RAW : GRID_W;
	localparam int SUM_W  = VAL_W + 2;

	logic [VAL_W-1:0] upper_mem [MAX_SIZE];
	logic [VAL_W-1:0] middle_mem [MAX_SIZE];

	logic [GRID_W-1:0] grid_q;
	logic [CW-1:0]     row_q, col_q;
	logic [VAL_W-1:0]  sweep_max_q;

	logic              valid_s1;
	logic [VAL_W-1:0]  cell_s1;
	logic [CW-1:0]     col_s1;
	logic              emit_s1, last_s1;
	logic [IDX_W-1:0]  row_idx_s1, col_idx_s1;
	logic [VAL_W-1:0]  up_rd_s1, mid_rd_s1, right_rd_s1;

	logic [VAL_W-1:0]  left_q;

	logic              out_valid_q, out_last_q;
	logic [VAL_W-1:0]  out_val_q, out_max_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;

	logic [NW-1:0]     grid_ext, size_n;
	logic [NW-1:0]     col_next, row_next;
	logic [CW-1:0]     col_plus;
	logic              accept, adv_s1, out_free, col_wrap, row_wrap;
	logic              emit_a, last_a;
	logic [SUM_W-1:0]  sum;
	logic [VAL_W-1:0]  new_val, delta, max_next;

	assign grid_ext = NW'(grid_q);
	always_comb begin
		if (grid_q < GRID_MIN) begin
			size_n = NW'(GRID_MIN);
		end else if (grid_ext > NW'(MAX_SIZE)) begin
			size_n = NW'(MAX_SIZE);
		end else begin
			size_n = grid_ext;
		end
	end

	assign out_free  = !out_valid_q || m_tready;
	assign adv_s1    = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || adv_s1;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign col_next = NW'(col_q) + NW'(1);
	assign row_next = NW'(row_q) + NW'(1);
	assign col_plus = col_q + CW'(1);
	assign col_wrap = (col_next == size_n);
	assign row_wrap = (row_next == size_n);
	assign emit_a   = (NW'(row_q) >= NW'(2)) && (NW'(col_q) >= NW'(1))
		&& (col_next < size_n);
	assign last_a   = row_wrap && ((col_next + NW'(1)) == size_n);

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= GRID_RESET;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_valid) begin
			grid_q <= cfg_data;
			row_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : CW'(row_next);
			end else begin
				col_q <= CW'(col_next);
			end
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1    <= s_tdata;
			col_s1     <= col_q;
			emit_s1    <= emit_a;
			last_s1    <= last_a;
			row_idx_s1 <= IDX_W'(row_q - CW'(1));
			col_idx_s1 <= IDX_W'(col_q);
		end
	end

	// line stores: read on accept, write back on advance
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_s1 <= upper_mem[col_q];
		end
		if (adv_s1) begin
			upper_mem[col_s1] <= mid_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mid_rd_s1   <= middle_mem[col_q];
			right_rd_s1 <= middle_mem[col_plus];
		end
		if (adv_s1) begin
			middle_mem[col_s1] <= cell_s1;
		end
	end

	// stencil arithmetic
	assign sum = SUM_W'(up_rd_s1) + SUM_W'(left_q) + SUM_W'(right_rd_s1)
		+ SUM_W'(cell_s1);
	assign new_val = sum[SUM_W-1:2];
	assign delta = (new_val >= mid_rd_s1) ? (new_val - mid_rd_s1) : (mid_rd_s1 - new_val);
	assign max_next = (delta > sweep_max_q) ? delta : sweep_max_q;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			left_q <= mid_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_max_q <= '0;
		end else if (cfg_valid) begin
			sweep_max_q <= '0;
		end else if (adv_s1 && emit_s1) begin
			sweep_max_q <= last_s1 ? '0 : max_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			out_val_q  <= new_val;
			out_row_q  <= row_idx_s1;
			out_col_q  <= col_idx_s1;
			out_max_q  <= max_next;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0, out_max_q, out_col_q, out_row_q, out_val_q};

endmodule
